### hw/rtl/swmr_pkg.sv
// shared types and constants for the sliding window range core
package swmr_pkg;

   localparam int RANGE_BITS = 20;
   localparam int CFG_BITS   = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic last_issue;
      logic out_free;
   } dp_sts_type;

endpackage

### hw/rtl/swmr_ram.sv
// generic single write, single read ram with registered read data
module swmr_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/swmr_ctrl.sv
// controller state machine for the sliding window range core
module swmr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  swmr_pkg::dp_sts_type  sts,
   output swmr_pkg::ctl_cmd_type cmd
);
   import swmr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.accept   = 1'b0;
      cmd.rd_issue = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.finish = sts.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

### hw/rtl/swmr_datapath.sv
// window store, min/max scan, best range and result register
module swmr_datapath #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  swmr_pkg::ctl_cmd_type                cmd,
   output swmr_pkg::dp_sts_type                 sts,
   input  logic                                 csr_write_enable,
   input  logic [swmr_pkg::CFG_BITS-1:0]        csr_write_data,
   input  logic [SAMPLE_BITS-1:0]               req_sample_value,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_window_full,
   output logic [swmr_pkg::RANGE_BITS-1:0]      rsp_window_range,
   output logic [swmr_pkg::RANGE_BITS-1:0]      rsp_best_range,
   output logic                                 rsp_set_done
);
   import swmr_pkg::*;

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   logic [CFG_BITS-1:0]    window_size_ff;
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SAMPLE_BITS-1:0] best_ff, best_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       reads_left_ff, reads_left_in;
   logic                   rd_valid_ff;
   logic [SAMPLE_BITS-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic                   full_ff, last_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_full_ff, rsp_done_ff;
   logic [RANGE_BITS-1:0]  rsp_range_ff, rsp_best_ff;

   logic [CNT_W-1:0]       win_eff;
   logic [CNT_W-1:0]       count_inc;
   logic                   full_now;
   logic [PTR_W-1:0]       wr_ptr_dec;
   logic [PTR_W-1:0]       rd_ptr_dec;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic [SAMPLE_BITS-1:0] range_val;
   logic [SAMPLE_BITS-1:0] range_out;
   logic [SAMPLE_BITS-1:0] best_out;
   logic [SAMPLE_BITS+RANGE_BITS-1:0] range_ext, best_ext;

   // window size clamped to 1..WINDOW_MAX
   always_comb begin
      if (window_size_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (int'(window_size_ff) > WINDOW_MAX) begin
         win_eff = CNT_W'(WINDOW_MAX);
      end else begin
         win_eff = CNT_W'(window_size_ff);
      end
   end

   assign count_inc  = (count_ff < CNT_W'(WINDOW_MAX)) ? count_ff + CNT_W'(1) : count_ff;
   assign full_now   = count_inc >= win_eff;
   assign wr_ptr_dec = (wr_ptr_ff == '0) ? PTR_W'(WINDOW_MAX - 1) : wr_ptr_ff - PTR_W'(1);
   assign rd_ptr_dec = (rd_ptr_ff == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_ptr_ff - PTR_W'(1);

   assign sts.need_scan  = full_now && (win_eff != CNT_W'(1));
   assign sts.last_issue = reads_left_ff == CNT_W'(1);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   swmr_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(WINDOW_MAX)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.accept),
      .wr_addr(wr_ptr_ff),
      .wr_data(req_sample_value),
      .rd_en  (cmd.rd_issue),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rd_data)
   );

   assign range_val = hi_ff - lo_ff;
   assign range_out = full_ff ? range_val : '0;
   assign best_out  = (full_ff && (range_val > best_ff)) ? range_val : best_ff;
   assign range_ext = {{RANGE_BITS{1'b0}}, range_out};
   assign best_ext  = {{RANGE_BITS{1'b0}}, best_out};

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      best_in       = best_ff;
      rd_ptr_in     = rd_ptr_ff;
      reads_left_in = reads_left_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.accept) begin
         wr_ptr_in     = (wr_ptr_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in      = count_inc;
         rd_ptr_in     = wr_ptr_dec;
         reads_left_in = win_eff - CNT_W'(1);
         hi_in         = req_sample_value;
         lo_in         = req_sample_value;
      end
      if (cmd.rd_issue) begin
         rd_ptr_in     = rd_ptr_dec;
         reads_left_in = reads_left_ff - CNT_W'(1);
      end
      if (rd_valid_ff) begin
         if (ram_rd_data > hi_ff) begin
            hi_in = ram_rd_data;
         end
         if (ram_rd_data < lo_ff) begin
            lo_in = ram_rd_data;
         end
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         best_in      = best_out;
         // closing beat of a set clears the set state
         if (last_ff) begin
            wr_ptr_in = '0;
            count_in  = '0;
            best_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CFG_BITS'(1);
         wr_ptr_ff      <= '0;
         count_ff       <= '0;
         best_ff        <= '0;
         reads_left_ff  <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_size_ff <= csr_write_data;
         end
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         best_ff       <= best_in;
         reads_left_ff <= reads_left_in;
         rd_valid_ff   <= cmd.rd_issue;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      if (cmd.accept) begin
         full_ff <= full_now;
         last_ff <= req_last_sample;
      end
      if (cmd.finish) begin
         rsp_full_ff  <= full_ff;
         rsp_done_ff  <= last_ff;
         rsp_range_ff <= range_ext[RANGE_BITS-1:0];
         rsp_best_ff  <= best_ext[RANGE_BITS-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_full  = rsp_full_ff;
   assign rsp_window_range = rsp_range_ff;
   assign rsp_best_range   = rsp_best_ff;
   assign rsp_set_done     = rsp_done_ff;

endmodule

### hw/rtl/sliding_window_max_range_core.sv
// sliding window min/max range core, top level
// Streams unsigned samples and reports, per beat, whether the last window_size
// samples of the current set are all present, the max minus min over them and
// the largest such range seen in the set so far. A beat with last_sample set
// closes the set: its result carries the final best range and the window,
// sample count and best range clear for the next set. An accepted beat goes
// straight to the result while the window is not full or the window size is
// one; otherwise the window scan reads one stored sample per cycle through
// the single read port of the window store. No clearing pass is needed after
// reset. window_size is written through csr_write_enable and csr_write_data;
// the user must write it only while the core is idle, which the core itself
// does not enforce. 0 acts as 1 and values above WINDOW_MAX act as WINDOW_MAX.
// A finished result waits in an output register so that the next beat is
// accepted while the result is still stalled.
module sliding_window_max_range_core #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample beats in
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_BITS-1:0]           req_sample_value,
   input  logic                             req_last_sample,
   // result beats out
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_window_full,
   output logic [swmr_pkg::RANGE_BITS-1:0]  rsp_window_range,
   output logic [swmr_pkg::RANGE_BITS-1:0]  rsp_best_range,
   output logic                             rsp_set_done,
   // window size register
   input  logic                             csr_write_enable,
   input  logic [swmr_pkg::CFG_BITS-1:0]    csr_write_data
);
   import swmr_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequencing: accept, scan the older window entries and drain when a scan is needed, load result
   swmr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // storage, min/max tracking and the result register
   swmr_datapath #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_sample_value(req_sample_value),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_full (rsp_window_full),
      .rsp_window_range(rsp_window_range),
      .rsp_best_range  (rsp_best_range),
      .rsp_set_done    (rsp_set_done)
   );

endmodule
